@@ rtl/sftd_pkg.sv @@
// Shared types and constants of the serial frame telemetry decoder.
// No dependencies; every file of the block but sftd_if.sv imports this package.
package sftd_pkg;

  // Frame framing bytes
  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  // Address and command pairs of the two known frame types
  localparam logic [7:0] ADDR_STATUS = 8'h21;
  localparam logic [7:0] CMD_STATUS  = 8'h64;
  localparam logic [7:0] ADDR_RIDER  = 8'h20;
  localparam logic [7:0] CMD_RIDER   = 8'h65;

  // Frame layout
  localparam int unsigned PAY_COUNT    = 6;  // payload bytes kept across frames
  localparam int unsigned PAY_FIRST    = 6;  // position of first kept payload byte
  localparam int unsigned HEADER_BYTES = 6;  // frame total is length plus this

  // Frame kind codes
  localparam logic [1:0] KIND_OTHER  = 2'd0;
  localparam logic [1:0] KIND_STATUS = 2'd1;
  localparam logic [1:0] KIND_RIDER  = 2'd2;

  typedef struct packed {
    logic        checksum_ok;
    logic [1:0]  frame_kind;
    logic [7:0]  speed_mode;
    logic [7:0]  battery_level;
    logic [7:0]  light_state;
    logic [15:0] speed_raw;
    logic [7:0]  throttle_level;
    logic [7:0]  brake_level;
  } result_t;

endpackage

@@ rtl/sftd_if.sv @@
// Valid/ready channel interfaces of the serial frame telemetry decoder.
// Depends on nothing; one interface for received bytes, one for results.
interface sftd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sftd_result_if;
  logic        valid;
  logic        ready;
  logic        checksum_ok;
  logic [1:0]  frame_kind;
  logic [7:0]  speed_mode;
  logic [7:0]  battery_level;
  logic [7:0]  light_state;
  logic [15:0] speed_raw;
  logic [7:0]  throttle_level;
  logic [7:0]  brake_level;

  modport source (output valid, output checksum_ok, output frame_kind, output speed_mode,
                  output battery_level, output light_state, output speed_raw,
                  output throttle_level, output brake_level, input ready);
  modport sink   (input valid, input checksum_ok, input frame_kind, input speed_mode,
                  input battery_level, input light_state, input speed_raw,
                  input throttle_level, input brake_level, output ready);
endinterface

@@ rtl/sftd_parser.sv @@
// Frame parser: position counter, header/checksum capture, kept payload and held telemetry.
// Depends on sftd_pkg. Processes one byte per cycle when step_i is high.
module sftd_parser #(
  parameter int unsigned MAX_FRAME_BYTES = 96
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  output logic              res_valid_o,
  output sftd_pkg::result_t res_o
);
  import sftd_pkg::*;

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [PosW-1:0] POS_MAX = PosW'(MAX_FRAME_BYTES);

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      addr_q, addr_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [15:0]     sum_q, sum_d;
  logic [7:0]      cklo_q, cklo_d;
  logic [7:0]      pay_q [PAY_COUNT];
  logic [7:0]      pay_d [PAY_COUNT];
  logic [7:0]      mode_q, mode_d;
  logic [7:0]      batt_q, batt_d;
  logic [7:0]      light_q, light_d;
  logic [15:0]     speed_q, speed_d;
  logic [7:0]      thr_q, thr_d;
  logic [7:0]      brake_q, brake_d;

  logic [PosW-1:0] pos_inc;
  logic [8:0]      pos9;
  logic [8:0]      inc9;
  logic            done;
  logic            ok;
  logic [1:0]      kind;

  always_comb begin
    pos_d   = pos_q;
    len_d   = len_q;
    addr_d  = addr_q;
    cmd_d   = cmd_q;
    sum_d   = sum_q;
    cklo_d  = cklo_q;
    pay_d   = pay_q;
    mode_d  = mode_q;
    batt_d  = batt_q;
    light_d = light_q;
    speed_d = speed_q;
    thr_d   = thr_q;
    brake_d = brake_q;
    done    = 1'b0;
    ok      = 1'b0;
    kind    = KIND_OTHER;
    pos_inc = pos_q + PosW'(1);
    pos9    = 9'(pos_q);
    inc9    = 9'(pos_inc);

    if (pos_q == PosW'(0)) begin
      // Hunt for the first sync byte
      if (byte_i == SYNC_FIRST) begin
        pos_d = PosW'(1);
        sum_d = 16'd0;
      end
    end else if (pos_q == PosW'(1)) begin
      pos_d = (byte_i == SYNC_SECOND) ? PosW'(2) : PosW'(0);
    end else begin
      if (pos_q == PosW'(2)) len_d  = byte_i;
      if (pos_q == PosW'(3)) addr_d = byte_i;
      if (pos_q == PosW'(4)) cmd_d  = byte_i;
      for (int i = 0; i < PAY_COUNT; i++) begin
        if (pos_q == PosW'(PAY_FIRST + i)) pay_d[i] = byte_i;
      end
      if (pos9 <= 9'(len_d) + 9'd3) sum_d = sum_q + 16'(byte_i);
      if (pos9 == 9'(len_d) + 9'd4) cklo_d = byte_i;

      done = (inc9 >= 9'(HEADER_BYTES)) && (inc9 >= 9'(len_d) + 9'(HEADER_BYTES));
      if (done) begin
        ok = (~sum_d) == {byte_i, cklo_d};
        if (ok && addr_d == ADDR_STATUS && cmd_d == CMD_STATUS) begin
          mode_d  = pay_d[0];
          batt_d  = pay_d[1];
          light_d = pay_d[2];
          speed_d = {pay_d[5], pay_d[4]};
          kind    = KIND_STATUS;
        end else if (ok && addr_d == ADDR_RIDER && cmd_d == CMD_RIDER) begin
          thr_d   = pay_d[1];
          brake_d = pay_d[2];
          kind    = KIND_RIDER;
        end
        pos_d = PosW'(0);
      end else if (pos_inc >= POS_MAX) begin
        // Overlong frame: drop without a result
        pos_d = PosW'(0);
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  assign res_valid_o          = step_i && done;
  assign res_o.checksum_ok    = ok;
  assign res_o.frame_kind     = kind;
  assign res_o.speed_mode     = mode_d;
  assign res_o.battery_level  = batt_d;
  assign res_o.light_state    = light_d;
  assign res_o.speed_raw      = speed_d;
  assign res_o.throttle_level = thr_d;
  assign res_o.brake_level    = brake_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      addr_q  <= '0;
      cmd_q   <= '0;
      sum_q   <= '0;
      cklo_q  <= '0;
      for (int i = 0; i < PAY_COUNT; i++) pay_q[i] <= '0;
      mode_q  <= '0;
      batt_q  <= '0;
      light_q <= '0;
      speed_q <= '0;
      thr_q   <= '0;
      brake_q <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      addr_q  <= addr_d;
      cmd_q   <= cmd_d;
      sum_q   <= sum_d;
      cklo_q  <= cklo_d;
      pay_q   <= pay_d;
      mode_q  <= mode_d;
      batt_q  <= batt_d;
      light_q <= light_d;
      speed_q <= speed_d;
      thr_q   <= thr_d;
      brake_q <= brake_d;
    end
  end

endmodule

@@ rtl/serial_frame_telemetry_decoder_unit.sv @@
// Top level of the serial frame telemetry decoder: input register, parser, result register.
// Depends on sftd_pkg, sftd_if.sv (channel interfaces) and sftd_parser.
// A frame's last byte enters the input register; the parser then loads the result register.
// One byte per cycle unless a result stalls; the parser updates all frame state in one pass.
// Ready stays high while the result register is free or being drained this cycle.
// Reset: asynchronous, active low; position, sums, kept payload and held values clear to zero.
module serial_frame_telemetry_decoder_unit #(
  parameter int unsigned MAX_FRAME_BYTES = 96
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sftd_byte_if.sink     in_i,
  sftd_result_if.source out_o
);
  import sftd_pkg::*;

  // Input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;

  // Result register
  logic    out_valid_q, out_valid_d;
  result_t out_data_q;

  logic    advance;
  logic    step;
  logic    res_valid;
  result_t res;

  // Advance the pipe whenever the result slot is free or drains this cycle
  assign advance    = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.valid && in_i.ready) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  sftd_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (s1_byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Hold a finished result until the request is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.rx_byte;
    end
    if (res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.checksum_ok    = out_data_q.checksum_ok;
  assign out_o.frame_kind     = out_data_q.frame_kind;
  assign out_o.speed_mode     = out_data_q.speed_mode;
  assign out_o.battery_level  = out_data_q.battery_level;
  assign out_o.light_state    = out_data_q.light_state;
  assign out_o.speed_raw      = out_data_q.speed_raw;
  assign out_o.throttle_level = out_data_q.throttle_level;
  assign out_o.brake_level    = out_data_q.brake_level;

endmodule

@@ sim/sftd_frame_checker.sv @@
// Frame checker for the serial frame telemetry decoder: follows the byte and result channels.
// It predicts every frame result from the accepted bytes and compares it field by field.
// Depends on sftd_pkg and the channel interfaces of sftd_if.sv.
module sftd_frame_checker
  import sftd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 96
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sftd_byte_if        byte_i,
  sftd_result_if      result_i,
  output int unsigned pending_o,
  output int unsigned mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Parser state as the block should hold it
  logic [6:0]  frame_pos;
  logic [7:0]  frame_len;
  logic [7:0]  frame_addr;
  logic [7:0]  frame_cmd;
  logic [15:0] frame_sum;
  logic [7:0]  cksum_lo;
  logic [7:0]  kept_payload [PAY_COUNT];
  result_t     held_view;

  result_t     expected_reports [$];
  int unsigned mismatches = 0;

  // Advance the parser by one byte; queue a result when a frame completes.
  task automatic advance_parser(input logic [7:0] rx);
    int unsigned p;
    int unsigned nxt;
    logic [15:0] rx_cksum;
    logic        sum_ok;
    p = frame_pos;
    if (p == 0) begin
      if (rx == SYNC_FIRST) begin
        frame_pos = 7'd1;
        frame_sum = '0;
      end
      return;
    end
    if (p == 1) begin
      frame_pos = (rx == SYNC_SECOND) ? 7'd2 : 7'd0;
      return;
    end
    case (p)
      2: frame_len = rx;
      3: frame_addr = rx;
      4: frame_cmd = rx;
      default: ;
    endcase
    if (p >= PAY_FIRST && p < PAY_FIRST + PAY_COUNT) kept_payload[p - PAY_FIRST] = rx;
    if (p <= int'(frame_len) + 3) frame_sum = frame_sum + rx;
    if (p == int'(frame_len) + 4) cksum_lo = rx;
    nxt = p + 1;
    if (nxt >= HEADER_BYTES && nxt >= int'(frame_len) + HEADER_BYTES) begin
      rx_cksum = {rx, cksum_lo};
      sum_ok   = (~frame_sum == rx_cksum);
      held_view.checksum_ok = sum_ok;
      held_view.frame_kind  = KIND_OTHER;
      if (sum_ok && frame_addr == ADDR_STATUS && frame_cmd == CMD_STATUS) begin
        held_view.speed_mode    = kept_payload[0];
        held_view.battery_level = kept_payload[1];
        held_view.light_state   = kept_payload[2];
        held_view.speed_raw     = {kept_payload[5], kept_payload[4]};
        held_view.frame_kind    = KIND_STATUS;
      end else if (sum_ok && frame_addr == ADDR_RIDER && frame_cmd == CMD_RIDER) begin
        held_view.throttle_level = kept_payload[1];
        held_view.brake_level    = kept_payload[2];
        held_view.frame_kind     = KIND_RIDER;
      end
      expected_reports.push_back(held_view);
      frame_pos = '0;
      return;
    end
    if (nxt >= MAX_FRAME_BYTES) nxt = 0;
    frame_pos = 7'(nxt);
  endtask

  task automatic check_field(input string field_name, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field_name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      frame_pos  = '0;
      frame_len  = '0;
      frame_addr = '0;
      frame_cmd  = '0;
      frame_sum  = '0;
      cksum_lo   = '0;
      foreach (kept_payload[i]) kept_payload[i] = '0;
      held_view  = '0;
      expected_reports.delete();
      pending_o        <= 0;
      mismatch_count_o <= mismatches;
    end else begin
      // Compare first: a byte taken at this edge cannot have its result out yet
      if (result_i.valid && result_i.ready) begin
        if (expected_reports.size() == 0) begin
          $error("frame result 0x%0h with no frame pending", result_i.frame_kind);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("checksum_ok", want.checksum_ok, result_i.checksum_ok);
          check_field("frame_kind", want.frame_kind, result_i.frame_kind);
          check_field("speed_mode", want.speed_mode, result_i.speed_mode);
          check_field("battery_level", want.battery_level, result_i.battery_level);
          check_field("light_state", want.light_state, result_i.light_state);
          check_field("speed_raw", want.speed_raw, result_i.speed_raw);
          check_field("throttle_level", want.throttle_level, result_i.throttle_level);
          check_field("brake_level", want.brake_level, result_i.brake_level);
        end
      end
      if (byte_i.valid && byte_i.ready) advance_parser(byte_i.rx_byte);
      pending_o        <= expected_reports.size();
      mismatch_count_o <= mismatches;
    end
  end

endmodule

@@ sim/tb_serial_frame_telemetry_decoder_unit.sv @@
// Top of the decoder testbench: clock, reset, byte stimulus and result backpressure.
// Depends on sftd_pkg, sftd_if.sv, the decoder RTL and sim/sftd_frame_checker.sv.
// The checker predicts and compares; this module only drives and gives the verdict.
module tb_serial_frame_telemetry_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sftd_pkg::*;

  localparam int unsigned FRAME_LIMIT  = 96;    // overlong frames drop at this byte count
  localparam int unsigned BYTE_TARGET  = 1200;  // frame bytes to offer in the random part
  localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off, fills the block
  localparam int unsigned DRAIN_CYCLES = 20;    // extra wait after the drain for late results
  localparam int unsigned DRAIN_GUARD  = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned tx_idle_pct   = 18;
  int unsigned rx_idle_pct   = 72;
  logic        hold_off_req  = 1'b0;
  logic        hold_off_done = 1'b0;
  int unsigned pending;
  int unsigned mismatch_count;
  int unsigned frame_bytes_sent = 0;
  logic [7:0]  frame_q [$];

  sftd_byte_if   byte_ch ();
  sftd_result_if result_ch ();

  serial_frame_telemetry_decoder_unit #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_ch),
    .out_o (result_ch)
  );

  sftd_frame_checker #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .byte_i          (byte_ch),
    .result_i        (result_ch),
    .pending_o       (pending),
    .mismatch_count_o(mismatch_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case a request never completes
  initial begin
    #2ms;
    $display("tb_serial_frame_telemetry_decoder_unit: FAIL");
    $finish;
  end

  // Offer one byte and hold it until the block takes the request.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
  endtask

  task automatic play_queue();
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
  endtask

  // Build a whole frame of length len: header, length, address, command, filler
  // up to the summed range, then the inverted sum little endian. With bad_sum
  // one checksum bit is flipped. Short lengths let the checksum take the place
  // of the command, as the block sees it.
  task automatic queue_frame(input logic [7:0] len, input logic [7:0] addr,
                             input logic [7:0] cmd, input bit bad_sum);
    logic [7:0]  body [$];
    logic [15:0] sum;
    logic [15:0] cksum;
    body.push_back(len);
    body.push_back(addr);
    body.push_back(cmd);
    while (body.size() < int'(len) + 2) body.push_back(8'($urandom_range(255)));
    while (body.size() > int'(len) + 2) void'(body.pop_back());
    sum = '0;
    foreach (body[i]) sum = sum + body[i];
    cksum = ~sum;
    if (bad_sum) cksum = cksum ^ (16'd1 << $urandom_range(15));
    frame_q.push_back(SYNC_FIRST);
    frame_q.push_back(SYNC_SECOND);
    foreach (body[i]) frame_q.push_back(body[i]);
    frame_q.push_back(cksum[7:0]);
    frame_q.push_back(cksum[15:8]);
    frame_bytes_sent += int'(len) + HEADER_BYTES;
  endtask

  // Pick a short frame length, with an occasional longer one.
  function automatic logic [7:0] pick_len();
    if ($urandom_range(99) < 85) return 8'($urandom_range(12, 0));
    return 8'($urandom_range(60, 13));
  endfunction

  // Receiver: random backpressure, plus one long hold-off on request.
  initial begin
    result_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end
      result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    int unsigned pick;
    int unsigned cut;
    int unsigned guard;
    logic [7:0]  len;
    logic [7:0]  addr;
    logic [7:0]  cmd;

    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= 8'h00;
    rst_ni          <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle line bytes at both extremes, then a bad second byte
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    frame_q.push_back(SYNC_FIRST);
    frame_q.push_back(8'h00);
    // A repeated sync byte aborts the header and is not taken as a new start
    frame_q.push_back(SYNC_FIRST);
    frame_q.push_back(SYNC_FIRST);
    // Zero length: the checksum low byte doubles as the command
    queue_frame(8'd0, 8'h00, 8'h00, 1'b0);
    // Short status reply: the checksum bytes land in the last kept payload bytes
    queue_frame(8'd6, ADDR_STATUS, CMD_STATUS, 1'b0);
    play_queue();

    while (frame_bytes_sent < BYTE_TARGET) begin
      // Move through the idling phases; hold off the receiver once in the last
      if (frame_bytes_sent >= 2 * BYTE_TARGET / 3) begin
        tx_idle_pct  <= 0;
        rx_idle_pct  <= 0;
        hold_off_req <= 1'b1;
      end else if (frame_bytes_sent >= BYTE_TARGET / 3) begin
        tx_idle_pct <= 72;
        rx_idle_pct <= 18;
      end

      pick = $urandom_range(99);
      if (pick < 40) begin
        queue_frame(pick_len(), ADDR_STATUS, CMD_STATUS, $urandom_range(9) == 0);
      end else if (pick < 62) begin
        queue_frame(pick_len(), ADDR_RIDER, CMD_RIDER, $urandom_range(9) == 0);
      end else if (pick < 72) begin
        // Unknown or near-miss address and command pairs
        addr = ($urandom_range(1)) ? 8'($urandom_range(255)) : ADDR_STATUS;
        cmd  = ($urandom_range(1)) ? 8'($urandom_range(255)) : CMD_RIDER;
        queue_frame(pick_len(), addr, cmd, $urandom_range(3) == 0);
      end else if (pick < 75) begin
        // Frame that completes right at, or one byte before, the byte limit
        len = 8'(FRAME_LIMIT - HEADER_BYTES - $urandom_range(1));
        if ($urandom_range(1)) queue_frame(len, ADDR_STATUS, CMD_STATUS, 1'b0);
        else queue_frame(len, ADDR_RIDER, CMD_RIDER, 1'b0);
      end else if (pick < 78) begin
        // Overlong frame: dropped without a result once the limit is hit
        len = ($urandom_range(3) == 0) ? 8'hFF :
              8'($urandom_range(254, FRAME_LIMIT - HEADER_BYTES + 1));
        frame_q.push_back(SYNC_FIRST);
        frame_q.push_back(SYNC_SECOND);
        frame_q.push_back(len);
        while (frame_q.size() < FRAME_LIMIT) frame_q.push_back(8'($urandom_range(255)));
        frame_bytes_sent += FRAME_LIMIT;
      end else if (pick < 86) begin
        // Line noise between frames
        repeat ($urandom_range(6, 1)) frame_q.push_back(8'($urandom_range(255)));
      end else if (pick < 92) begin
        // Broken header: sync byte followed by anything but the second sync byte
        frame_q.push_back(SYNC_FIRST);
        do cut = $urandom_range(255); while (cut == SYNC_SECOND);
        frame_q.push_back(8'(cut));
      end else begin
        // Truncated frame; the next frame's bytes land inside it
        queue_frame(pick_len(), ADDR_STATUS, CMD_STATUS, 1'b0);
        cut = $urandom_range(frame_q.size() - 3, 1);
        repeat (cut) void'(frame_q.pop_back());
      end
      play_queue();
    end

    byte_ch.valid <= 1'b0;
    @(posedge clk_i);

    // Drain what is still owed, then give late results a chance to show up
    guard = 0;
    while (pending != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending != 0) $error("%0d frame results never arrived", pending);
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb_serial_frame_telemetry_decoder_unit: PASS");
    end else begin
      $display("tb_serial_frame_telemetry_decoder_unit: FAIL");
    end
    $finish;
  end

endmodule
